>>> rtl/sct_pkg.sv
// Shared types, constants and sizes of the shell command tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

    localparam int LIMIT_W    = 12;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int MAX_RES    = 3;

    localparam logic [LIMIT_W-1:0] WORD_LIMIT_RESET = 12'd255;

    localparam logic [7:0] CH_PIPE  = 8'h7C;   // '|'
    localparam logic [7:0] CH_LT    = 8'h3C;   // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;   // '>'
    localparam logic [7:0] CH_AMP   = 8'h26;   // '&'
    localparam logic [7:0] CH_DQUOT = 8'h22;   // '"'
    localparam logic [7:0] CH_SQUOT = 8'h27;   // single quote
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        K_BYTE   = 3'd0,
        K_WEND   = 3'd1,
        K_PIPE   = 3'd2,
        K_IN     = 3'd3,
        K_OUT    = 3'd4,
        K_APPEND = 3'd5,
        K_BG     = 3'd6,
        K_END    = 3'd7
    } kind_t;

    typedef enum logic [4:0] {
        M_IDLE   = 5'b00001,
        M_PLAIN  = 5'b00010,
        M_QUOTED = 5'b00100,
        M_GT     = 5'b01000,
        M_CUT    = 5'b10000
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
        logic       last;
    } entry_t;

    // Up to three results produced by one item, entry 0 first.
    typedef struct packed {
        logic [1:0]               n;
        entry_t [MAX_RES-1:0]     e;
    } push_t;

endpackage

`default_nettype wire

>>> rtl/shell_command_tokenizer_unit.sv
// Top level of the shell command tokenizer: input register, lexer, result queue.
`timescale 1ns / 1ps
`default_nettype none
//
// Shell command tokenizer.
// Input channel (s_*): one transaction per command-line byte (s_tuser = 0, byte in
// s_tdata, zero bytes are dropped) or one end-of-line transaction (s_tuser = 1).
// Output channel (m_*): one transaction per token result; m_tuser is the token
// kind (word byte, word end, pipe, input, output, append, background, end),
// m_tdata the word byte or zero, m_tlast marks the final result of an input item.
// A '>' is held until the next byte so that '>>' becomes append.
// Configuration: cfg_we writes cfg_wdata as the word length limit (reset 255,
// zero acts as 1); write only while the block is idle.
// Path: an accepted item is captured in the input register, is lexed into the result
// queue once the queue has room for its worst-case results, and its first result shows
// on m_tvalid as soon as it is written into the queue.
// Throughput: one item per cycle while items give at most one result each and m_tready
// stays high; an item giving more results is drained one result at a time through the
// one-entry output port of the eight-entry result queue.
// Stall: when m_tready is low the queue fills; once fewer than three entries are
// free an item in the input register is held there and s_tready drops.
// Reset: rst_n clears the lexer to idle, empties the queue and restores the limit.
//
module shell_command_tokenizer_unit
    import sct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // byte_req[7:0]
    input  wire logic               s_tuser,    // action
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,    // char_out[7:0]
    output logic [2:0]              m_tuser,    // kind[2:0]
    output logic                    m_tlast,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata
);

    logic               in_valid_reg, in_valid_next;
    logic               in_action_reg;
    logic [7:0]         in_byte_reg;
    logic [LIMIT_W-1:0] word_limit_reg, word_limit_next;
    logic               room;
    logic               fire;
    logic               s_accept;
    push_t              push;

    // Lex the held item as soon as the queue can take its worst-case results.
    always_comb
    begin
        fire            = in_valid_reg && room;
        s_tready        = !in_valid_reg || room;
        s_accept        = s_tvalid && s_tready;
        in_valid_next   = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        word_limit_next = cfg_we ? cfg_wdata : word_limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            word_limit_reg <= WORD_LIMIT_RESET;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            word_limit_reg <= word_limit_next;
        end
    end

    // Payload of the input register: load on every accepted transaction.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    sct_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .action     (in_action_reg),
        .byte_in    (in_byte_reg),
        .word_limit (word_limit_reg),
        .push       (push)
    );

    sct_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/sct_lexer.sv
// Lexer state and single-pass result generation for one character item.
`timescale 1ns / 1ps
`default_nettype none

module sct_lexer
    import sct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic               action,
    input  wire logic [7:0]         byte_in,
    input  wire logic [LIMIT_W-1:0] word_limit,
    output push_t                   push
);

    typedef struct packed {
        push_t              r;
        mode_t              mode;
        logic               q;
        logic [LIMIT_W-1:0] cnt;
    } lex_t;

    mode_t              mode_reg, mode_next;
    logic               quote_single_reg, quote_single_next;
    logic [LIMIT_W-1:0] count_reg, count_next;

    lex_t               cur;
    lex_t               nx;
    logic [7:0]         qch;
    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W-1:0] cnt_inc;

    function automatic push_t put_res(push_t s, kind_t k, logic [7:0] c);
        push_t r;
        r = s;
        if (s.n != 2'd3)
        begin
            r.e[s.n].kind     = k;
            r.e[s.n].char_out = c;
            r.e[s.n].last     = 1'b0;
            r.n               = s.n + 2'd1;
        end
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic lex_t plain_byte(lex_t s, logic [7:0] b, logic [LIMIT_W-1:0] l);
        lex_t               o;
        logic [LIMIT_W-1:0] c;
        o   = s;
        c   = s.cnt + LIMIT_W'(1);
        o.r = put_res(o.r, K_BYTE, b);
        if (c >= l)
        begin
            o.r    = put_res(o.r, K_WEND, 8'd0);
            o.mode = M_IDLE;
            o.cnt  = '0;
        end
        else
        begin
            o.mode = M_PLAIN;
            o.cnt  = c;
        end
        return o;
    endfunction

    // Start a new token from the idle state.
    function automatic lex_t fresh(lex_t s, logic [7:0] b, logic [LIMIT_W-1:0] l);
        lex_t o;
        o      = s;
        o.mode = M_IDLE;
        o.cnt  = '0;
        priority if (is_space(b))
        begin
            o.mode = M_IDLE;
        end
        else if (b == CH_PIPE)
        begin
            o.r = put_res(o.r, K_PIPE, 8'd0);
        end
        else if (b == CH_LT)
        begin
            o.r = put_res(o.r, K_IN, 8'd0);
        end
        else if (b == CH_AMP)
        begin
            o.r = put_res(o.r, K_BG, 8'd0);
        end
        else if (b == CH_GT)
        begin
            o.mode = M_GT;
        end
        else if ((b == CH_DQUOT) || (b == CH_SQUOT))
        begin
            o.mode = M_QUOTED;
            o.q    = (b == CH_SQUOT);
        end
        else
        begin
            o = plain_byte(o, b, l);
        end
        return o;
    endfunction

    always_comb
    begin
        lim      = (word_limit == '0) ? LIMIT_W'(1) : word_limit;
        qch      = quote_single_reg ? CH_SQUOT : CH_DQUOT;
        cnt_inc  = count_reg + LIMIT_W'(1);
        cur.r    = '0;
        cur.mode = mode_reg;
        cur.q    = quote_single_reg;
        cur.cnt  = count_reg;
        nx       = cur;

        if (action)
        begin
            if ((mode_reg == M_PLAIN) || (mode_reg == M_QUOTED))
                nx.r = put_res(nx.r, K_WEND, 8'd0);
            else if (mode_reg == M_GT)
                nx.r = put_res(nx.r, K_OUT, 8'd0);
            nx.r    = put_res(nx.r, K_END, 8'd0);
            nx.mode = M_IDLE;
            nx.q    = 1'b0;
            nx.cnt  = '0;
        end
        else if (byte_in != 8'd0)
        begin
            unique case (mode_reg)
                M_PLAIN:
                begin
                    if (is_space(byte_in) || (byte_in == CH_PIPE) || (byte_in == CH_LT) ||
                        (byte_in == CH_GT) || (byte_in == CH_AMP))
                    begin
                        nx.r = put_res(nx.r, K_WEND, 8'd0);
                        nx   = fresh(nx, byte_in, lim);
                    end
                    else
                    begin
                        nx = plain_byte(nx, byte_in, lim);
                    end
                end
                M_QUOTED:
                begin
                    if (byte_in == qch)
                    begin
                        nx.r    = put_res(nx.r, K_WEND, 8'd0);
                        nx.mode = M_IDLE;
                        nx.cnt  = '0;
                    end
                    else
                    begin
                        nx.r = put_res(nx.r, K_BYTE, byte_in);
                        if (cnt_inc >= lim)
                        begin
                            nx.r    = put_res(nx.r, K_WEND, 8'd0);
                            nx.mode = M_CUT;
                            nx.cnt  = '0;
                        end
                        else
                        begin
                            nx.cnt = cnt_inc;
                        end
                    end
                end
                M_CUT:
                begin
                    // Swallow a closing quote that arrives right after the cut.
                    nx.mode = M_IDLE;
                    if (byte_in != qch)
                        nx = fresh(nx, byte_in, lim);
                end
                M_GT:
                begin
                    nx.mode = M_IDLE;
                    if (byte_in == CH_GT)
                    begin
                        nx.r = put_res(nx.r, K_APPEND, 8'd0);
                    end
                    else
                    begin
                        nx.r = put_res(nx.r, K_OUT, 8'd0);
                        nx   = fresh(nx, byte_in, lim);
                    end
                end
                default:
                begin
                    nx = fresh(nx, byte_in, lim);
                end
            endcase
        end

        // Mark the final result of this item.
        for (int i = 0; i < MAX_RES; i++)
            nx.r.e[i].last = ((2'(i) + 2'd1) == nx.r.n);

        push   = nx.r;
        push.n = fire ? nx.r.n : 2'd0;

        mode_next         = fire ? nx.mode : mode_reg;
        quote_single_next = fire ? nx.q : quote_single_reg;
        count_next        = fire ? nx.cnt : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= M_IDLE;
            quote_single_reg <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            count_reg        <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sct_result_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per cycle while m_tready is high.
`timescale 1ns / 1ps
`default_nettype none

module sct_result_fifo
    import sct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  push_t     push,
    output logic      room,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic [7:0] m_tdata,   // char_out[7:0]
    output logic [2:0] m_tuser,   // kind[2:0]
    output logic      m_tlast
);

    entry_t           mem [FIFO_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    entry_t           head;

    always_comb
    begin
        pop         = m_tvalid && m_tready;
        room        = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RES));
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
        head        = mem[rd_ptr_reg];
        m_tvalid    = (count_reg != '0);
        m_tdata     = head.char_out;
        m_tuser     = head.kind;
        m_tlast     = head.last;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (2'(i) < push.n)
                mem[wr_ptr_reg + PTR_W'(i)] <= push.e[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count exceeds depth");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RES)))
        else $error("results pushed without room for a full item");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop && (push.n == 2'd0)) |=> ($stable(count_reg) && $stable(rd_ptr_reg)))
        else $error("queue moved with no push and no pop");

endmodule

`default_nettype wire
